FILE: sv/mcfp_pkg.sv
`default_nettype none

package mcfp_pkg;

    localparam int PAYLOAD_MAX  = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int PAYLOAD_CAP  = (PAYLOAD_MAX < RESULT_LIMIT) ? PAYLOAD_MAX : RESULT_LIMIT;
    localparam int PIDX_W       = (PAYLOAD_CAP > 1) ? $clog2(PAYLOAD_CAP) : 1;
    localparam int PLEN_W       = PIDX_W + 1;

    localparam logic [4:0] CODE_NONE    = 5'd0;
    localparam logic [4:0] CODE_ACK     = 5'd1;
    localparam logic [4:0] CODE_SR      = 5'd16;
    localparam logic [4:0] CODE_SD      = 5'd17;
    localparam logic [4:0] CODE_UNKNOWN = 5'd18;

    localparam logic [7:0] CHAR_ACK   = 8'h06;
    localparam logic [7:0] CHAR_START = 8'h3A;
    localparam logic [7:0] CHAR_END   = 8'h23;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef struct packed {
        logic [4:0]        code;
        logic [PLEN_W-1:0] len;
        logic              trunc;
    } t_job;

    typedef struct packed {
        logic              we;
        logic [PIDX_W-1:0] addr;
        logic [7:0]        data;
    } t_pwr;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [4:0] code;
    } t_type_entry;

    localparam t_type_entry TYPE_TABLE [16] = '{
        '{2'd2, "G", "R", 8'h00, 5'd2},  '{2'd2, "G", "D", 8'h00, 5'd3},
        '{2'd3, "G", "V", "P",   5'd4},  '{2'd3, "G", "V", "N",   5'd5},
        '{2'd3, "G", "V", "D",   5'd6},  '{2'd3, "G", "V", "T",   5'd7},
        '{2'd2, "G", "g", 8'h00, 5'd8},  '{2'd2, "G", "t", 8'h00, 5'd9},
        '{2'd2, "G", "C", 8'h00, 5'd10}, '{2'd2, "G", "L", 8'h00, 5'd11},
        '{2'd2, "G", "G", 8'h00, 5'd12}, '{2'd1, "D", 8'h00, 8'h00, 5'd13},
        '{2'd2, "G", "W", 8'h00, 5'd14}, '{2'd1, "Q", 8'h00, 8'h00, 5'd15},
        '{2'd2, "S", "r", 8'h00, 5'd16}, '{2'd2, "S", "d", 8'h00, 5'd17}
    };

    function automatic logic [4:0] classify(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2, input logic [2:0] len);
        logic [4:0] code;
        logic       hit;
        code = CODE_UNKNOWN;
        for (int i = 0; i < 16; i++) begin
            hit = ({1'b0, TYPE_TABLE[i].len} == len) && (c0 == TYPE_TABLE[i].c0) &&
                  ((len < 3'd2) || (c1 == TYPE_TABLE[i].c1)) &&
                  ((len < 3'd3) || (c2 == TYPE_TABLE[i].c2));
            if (hit) begin
                code = TYPE_TABLE[i].code;
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mcfp_front.sv
`default_nettype none

module mcfp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_end,
    input  wire logic            i_full,
    output logic                 o_ready,
    output mcfp_pkg::t_pwr       o_pwr,
    output logic                 o_push,
    output mcfp_pkg::t_job       o_job
);
    import mcfp_pkg::*;

    logic              r_collecting, n_collecting;
    logic              r_have, n_have;
    logic              r_ack, n_ack;
    logic [7:0]        r_type_chars [3];
    logic [2:0]        r_type_len, n_type_len;
    logic              r_closed, n_closed;
    logic [PLEN_W-1:0] r_plen, n_plen;
    logic              r_ovf, n_ovf;
    logic [4:0]        r_found, n_found;
    logic              fire;
    logic              tc_we;
    logic              add;

    assign o_ready = !i_full;
    assign fire    = i_valid && o_ready;

    always_comb begin
        n_collecting = r_collecting;
        n_have       = r_have;
        n_ack        = r_ack;
        n_type_len   = r_type_len;
        n_closed     = r_closed;
        n_plen       = r_plen;
        n_ovf        = r_ovf;
        n_found      = r_found;
        tc_we        = 1'b0;
        add          = 1'b0;
        if (i_byte == CHAR_ACK) begin
            n_ack = 1'b1;
        end
        if (!r_have) begin
            if (!r_collecting) begin
                if (i_byte == CHAR_START) begin
                    n_collecting = 1'b1;
                    n_type_len   = 3'd0;
                    n_closed     = 1'b0;
                    n_plen       = '0;
                    n_ovf        = 1'b0;
                end
            end else if (i_byte == CHAR_END) begin
                n_collecting = 1'b0;
                n_have       = 1'b1;
                n_found      = classify(r_type_chars[0], r_type_chars[1], r_type_chars[2],
                                        r_type_len);
            end else if (!r_closed) begin
                if (i_byte >= CHAR_PLUS && i_byte <= CHAR_COLON) begin
                    n_closed = 1'b1;
                    add      = 1'b1;
                end else if (r_type_len < 3'd4) begin
                    tc_we      = (r_type_len < 3'd3);
                    n_type_len = r_type_len + 3'd1;
                end
            end else begin
                add = 1'b1;
            end
        end
        o_pwr.we   = 1'b0;
        o_pwr.addr = r_plen[PIDX_W-1:0];
        o_pwr.data = i_byte;
        if (add) begin
            if (r_plen < PLEN_W'(PAYLOAD_CAP)) begin
                o_pwr.we = fire;
                n_plen   = r_plen + PLEN_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_comb begin
        o_push      = fire && i_end;
        o_job.code  = n_found;
        o_job.len   = '0;
        o_job.trunc = 1'b0;
        if (n_ack) begin
            o_job.code = CODE_ACK;
        end else if (!n_have) begin
            o_job.code = CODE_NONE;
        end else if (n_found == CODE_SR || n_found == CODE_SD) begin
            o_job.len   = n_plen;
            o_job.trunc = n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && tc_we) begin
            r_type_chars[r_type_len[1:0]] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && i_end)) begin
            r_collecting <= 1'b0;
            r_have       <= 1'b0;
            r_ack        <= 1'b0;
            r_type_len   <= 3'd0;
            r_closed     <= 1'b0;
            r_plen       <= '0;
            r_ovf        <= 1'b0;
            r_found      <= CODE_NONE;
        end else if (fire) begin
            r_collecting <= n_collecting;
            r_have       <= n_have;
            r_ack        <= n_ack;
            r_type_len   <= n_type_len;
            r_closed     <= n_closed;
            r_plen       <= n_plen;
            r_ovf        <= n_ovf;
            r_found      <= n_found;
        end
    end

endmodule

`default_nettype wire

FILE: sv/mcfp_queue.sv
`default_nettype none

module mcfp_queue (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mcfp_pkg::t_pwr             i_pwr,
    input  wire logic                       i_push,
    input  wire mcfp_pkg::t_job             i_job,
    input  wire logic                       i_pop,
    input  wire logic [mcfp_pkg::PIDX_W-1:0] i_rd_idx,
    output logic                            o_full,
    output logic                            o_head_valid,
    output mcfp_pkg::t_job                  o_head,
    output logic [7:0]                      o_rd_data
);
    import mcfp_pkg::*;

    logic [7:0] r_mem [2][PAYLOAD_CAP];
    t_job       r_jobs [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [7:0] r_rd_data;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_jobs[r_rd_ptr];
    assign o_rd_data    = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_pwr.we) begin
            r_mem[r_wr_ptr][i_pwr.addr] <= i_pwr.data;
        end
        r_rd_data <= r_mem[r_rd_ptr][i_rd_idx];
        if (i_push) begin
            r_jobs[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/mcfp_back.sv
`default_nettype none

module mcfp_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_head_valid,
    input  wire mcfp_pkg::t_job              i_head,
    input  wire logic [7:0]                  i_rd_data,
    input  wire logic                        i_ready,
    output logic                             o_pop,
    output logic [mcfp_pkg::PIDX_W-1:0]      o_rd_idx,
    output logic                             o_valid,
    output logic [15:0]                      o_data,
    output logic                             o_last
);
    import mcfp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } t_state;

    t_state            r_state;
    logic [PIDX_W-1:0] r_idx;
    logic              r_valid;
    logic [15:0]       r_data;
    logic              r_last;
    logic              load;
    logic              more;
    logic              has_payload;

    assign has_payload = (i_head.len != '0);
    assign more        = has_payload && (({1'b0, r_idx} + PLEN_W'(1)) != i_head.len);
    assign load        = (r_state == S_SEND) && (!r_valid || i_ready);
    assign o_pop       = load && !more;
    assign o_rd_idx    = r_idx;
    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_data  <= '0;
            r_last  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_head_valid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (load) begin
                        r_last  <= !more;
                        r_data  <= {1'b0, i_head.trunc, has_payload,
                                    has_payload ? i_rd_data : 8'h00, i_head.code};
                        if (more) begin
                            r_idx   <= r_idx + PIDX_W'(1);
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/mount_command_frame_parser.sv
// Command frame parser for a mount serial link. Message bytes enter on the slave
// stream, one transaction per byte, with tlast on the final byte of a message; the
// front parser takes one byte per cycle. At message end the first complete ':'...'#'
// command is classified and queued together with its payload, which is stored in one
// of two payload banks, so the parser keeps taking the next message while the previous
// one drains; it stalls only when both banks hold undelivered messages. The drain
// sequencer picks up each queued message in its idle state, then for each result reads
// the payload memory and loads the output register, waiting while the output stalls.
// A message yields one result for most commands, up to PAYLOAD_CAP results for Sr
// and Sd payloads. No clearing pass follows reset.
`default_nettype none

module mount_command_frame_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [4:0] cmd_code, [12:5] payload_byte,
                                            // [13] payload_valid, [14] payload_truncated
    output logic             m_axis_tlast
);
    import mcfp_pkg::*;

    t_pwr              pwr;
    t_job              job;
    t_job              head;
    logic              push;
    logic              pop;
    logic              full;
    logic              head_valid;
    logic [PIDX_W-1:0] rd_idx;
    logic [7:0]        rd_data;

    mcfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_pwr   (pwr),
        .o_push  (push),
        .o_job   (job)
    );

    mcfp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pwr        (pwr),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .i_rd_idx     (rd_idx),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_rd_data    (rd_data)
    );

    mcfp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .i_rd_data    (rd_data),
        .i_ready      (m_axis_tready),
        .o_pop        (pop),
        .o_rd_idx     (rd_idx),
        .o_valid      (m_axis_tvalid),
        .o_data       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: sv/mcfp_checker.sv
`default_nettype none

module mcfp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    import mcfp_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output transaction dropped while stalled.");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Output payload changed while stalled.");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= CODE_UNKNOWN)
        else $error("Command code out of range.");

    a_payload_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |->
            (m_axis_tdata[4:0] == CODE_SR) || (m_axis_tdata[4:0] == CODE_SD))
        else $error("Payload byte on a command without payload.");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tlast)
        else $error("Result without payload is not the last of its message.");

endmodule

bind mount_command_frame_parser mcfp_checker u_mcfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mcfp_pkg::*;

    typedef enum logic [4:0] {
        CMD_NONE = 5'd0, CMD_ACK, CMD_GR, CMD_GD, CMD_GVP, CMD_GVN, CMD_GVD, CMD_GVT,
        CMD_G_LO_G, CMD_G_LO_T, CMD_GC, CMD_GL, CMD_GG, CMD_D, CMD_GW, CMD_Q,
        CMD_SR, CMD_SD, CMD_UNKNOWN
    } t_cmd;

    typedef struct packed {
        logic [4:0] code;
        logic [7:0] pbyte;
        logic       pvalid;
        logic       ptrunc;
        logic       plast;
    } t_frame_result;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_cmd       code;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    mount_command_frame_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Parser model state.
    logic       in_cmd = 1'b0;
    logic       cmd_done = 1'b0;
    logic       ack_flag = 1'b0;
    logic [7:0] tchars [3];
    logic [2:0] tlen = 3'd0;
    logic       tclosed = 1'b0;
    logic [7:0] pbuf [16];
    logic [4:0] plen = 5'd0;
    logic       pover = 1'b0;
    t_cmd       fcode = CMD_NONE;

    t_frame_result expected_results [$];
    t_frame_result step_results [$];
    logic [7:0]    msg_bytes [$];
    int            mismatches = 0;
    int            items_sent = 0;
    logic          stall_enable = 1'b1;

    string known_types [16] = '{"GR", "GD", "GVP", "GVN", "GVD", "GVT", "Gg", "Gt",
                                "GC", "GL", "GG", "D", "GW", "Q", "Sr", "Sd"};

    t_stim_row directed_rows [24] = '{
        '{8'h00, 1'b1, 1'b1, CMD_NONE},
        '{8'hFF, 1'b1, 1'b1, CMD_NONE},
        '{CHAR_START, 1'b0, 1'b0, CMD_NONE}, '{"G", 1'b0, 1'b0, CMD_NONE},
        '{"R", 1'b0, 1'b0, CMD_NONE}, '{CHAR_END, 1'b1, 1'b1, CMD_GR},
        '{CHAR_ACK, 1'b1, 1'b1, CMD_ACK},
        '{CHAR_START, 1'b0, 1'b0, CMD_NONE}, '{"S", 1'b0, 1'b0, CMD_NONE},
        '{"r", 1'b0, 1'b0, CMD_NONE}, '{CHAR_PLUS, 1'b0, 1'b0, CMD_NONE},
        '{"1", 1'b0, 1'b0, CMD_NONE}, '{CHAR_END, 1'b1, 1'b0, CMD_NONE},
        '{CHAR_START, 1'b0, 1'b0, CMD_NONE}, '{CHAR_END, 1'b1, 1'b1, CMD_UNKNOWN},
        '{CHAR_START, 1'b0, 1'b0, CMD_NONE}, '{"Q", 1'b0, 1'b0, CMD_NONE},
        '{CHAR_END, 1'b1, 1'b1, CMD_Q},
        '{CHAR_START, 1'b0, 1'b0, CMD_NONE}, '{"S", 1'b0, 1'b0, CMD_NONE},
        '{"d", 1'b0, 1'b0, CMD_NONE}, '{CHAR_END, 1'b1, 1'b1, CMD_SD},
        '{CHAR_START, 1'b0, 1'b0, CMD_NONE}, '{"X", 1'b1, 1'b1, CMD_NONE}
    };

    function automatic t_frame_result make_result(input logic [4:0] code,
                                                  input logic [7:0] b, input logic v,
                                                  input logic t, input logic l);
        t_frame_result r;
        r.code   = code;
        r.pbyte  = b;
        r.pvalid = v;
        r.ptrunc = t;
        r.plast  = l;
        return r;
    endfunction

    function automatic t_cmd classify_type();
        t_cmd code;
        code = CMD_UNKNOWN;
        case (tlen)
            3'd1: begin
                case (tchars[0])
                    "D": code = CMD_D;
                    "Q": code = CMD_Q;
                    default: ;
                endcase
            end
            3'd2: begin
                case ({tchars[0], tchars[1]})
                    "GR": code = CMD_GR;
                    "GD": code = CMD_GD;
                    "Gg": code = CMD_G_LO_G;
                    "Gt": code = CMD_G_LO_T;
                    "GC": code = CMD_GC;
                    "GL": code = CMD_GL;
                    "GG": code = CMD_GG;
                    "GW": code = CMD_GW;
                    "Sr": code = CMD_SR;
                    "Sd": code = CMD_SD;
                    default: ;
                endcase
            end
            3'd3: begin
                case ({tchars[0], tchars[1], tchars[2]})
                    "GVP": code = CMD_GVP;
                    "GVN": code = CMD_GVN;
                    "GVD": code = CMD_GVD;
                    "GVT": code = CMD_GVT;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return code;
    endfunction

    function automatic void store_payload(input logic [7:0] c);
        if (plen < PAYLOAD_CAP) begin
            pbuf[plen] = c;
            plen = plen + 5'd1;
        end else begin
            pover = 1'b1;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] c, input logic l);
        int  i;
        logic is_set;
        if (c == CHAR_ACK) begin
            ack_flag = 1'b1;
        end
        if (!cmd_done) begin
            if (!in_cmd) begin
                if (c == CHAR_START) begin
                    in_cmd  = 1'b1;
                    tlen    = 3'd0;
                    tclosed = 1'b0;
                    plen    = 5'd0;
                    pover   = 1'b0;
                end
            end else if (c == CHAR_END) begin
                in_cmd   = 1'b0;
                cmd_done = 1'b1;
                fcode    = classify_type();
            end else if (!tclosed) begin
                if (c >= CHAR_PLUS && c <= CHAR_COLON) begin
                    tclosed = 1'b1;
                    store_payload(c);
                end else if (tlen < 3'd4) begin
                    if (tlen < 3'd3) begin
                        tchars[tlen] = c;
                    end
                    tlen = tlen + 3'd1;
                end
            end else begin
                store_payload(c);
            end
        end
        if (l) begin
            is_set = (fcode == CMD_SR) || (fcode == CMD_SD);
            if (ack_flag) begin
                step_results.insert(step_results.size(),
                                    make_result(CMD_ACK, 8'h00, 1'b0, 1'b0, 1'b1));
            end else if (!cmd_done) begin
                step_results.insert(step_results.size(),
                                    make_result(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b1));
            end else if (is_set && plen != 5'd0) begin
                for (i = 0; i < plen; i++) begin
                    step_results.insert(step_results.size(),
                                        make_result(fcode, pbuf[i], 1'b1, pover,
                                                    i == plen - 1));
                end
            end else begin
                step_results.insert(step_results.size(),
                                    make_result(fcode, 8'h00, 1'b0, is_set && pover,
                                                1'b1));
            end
            in_cmd   = 1'b0;
            cmd_done = 1'b0;
            ack_flag = 1'b0;
            tlen     = 3'd0;
            tclosed  = 1'b0;
            plen     = 5'd0;
            pover    = 1'b0;
            fcode    = CMD_NONE;
        end
    endfunction

    task automatic send_item(input logic [7:0] d, input logic l, input logic typed,
                             input t_cmd code);
        if (stall_enable && $urandom_range(0, 99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        items_sent++;
        parse_byte(d, l);
        if (typed) begin
            expected_results.insert(expected_results.size(),
                                    make_result(code, 8'h00, 1'b0, 1'b0, 1'b1));
        end else begin
            foreach (step_results[i]) begin
                expected_results.insert(expected_results.size(), step_results[i]);
            end
        end
        step_results.delete();
    endtask

    function automatic logic [7:0] type_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while ((b >= CHAR_PLUS && b <= CHAR_COLON) || b == CHAR_END) begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CHAR_END) begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    task automatic add_command(input int family, input logic close);
        int    n;
        int    k;
        string tname;
        tname = "";
        msg_bytes.insert(msg_bytes.size(), CHAR_START);
        case (family)
            0: begin
                tname = $urandom_range(0, 1) ? "Sr" : "Sd";
                n = ($urandom_range(0, 6) == 0) ? $urandom_range(14, 20)
                                                : $urandom_range(0, 10);
            end
            1: begin
                tname = known_types[$urandom_range(0, 15)];
                n = $urandom_range(0, 4);
            end
            default: begin
                repeat ($urandom_range(0, 5)) msg_bytes.insert(msg_bytes.size(), type_char());
                n = $urandom_range(0, 5);
            end
        endcase
        for (k = 0; k < tname.len(); k++) begin
            msg_bytes.insert(msg_bytes.size(), tname[k]);
        end
        if (n > 0) begin
            msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(CHAR_PLUS, CHAR_COLON)));
        end
        for (k = 1; k < n; k++) begin
            msg_bytes.insert(msg_bytes.size(), body_char());
        end
        if (close) begin
            msg_bytes.insert(msg_bytes.size(), CHAR_END);
        end
    endtask

    task automatic build_message();
        int kind;
        kind = $urandom_range(0, 99);
        msg_bytes.delete();
        repeat ($urandom_range(0, 2)) begin
            msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(0, 255)));
        end
        if (kind < 40) begin
            add_command(0, 1'b1);
        end else if (kind < 65) begin
            add_command(1, 1'b1);
        end else if (kind < 80) begin
            add_command(2, 1'b1);
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 6)) begin
                msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(0, 255)));
            end
        end else if (kind < 95) begin
            add_command($urandom_range(0, 2), 1'b0);
        end else begin
            add_command(0, 1'b1);
            add_command($urandom_range(0, 2), 1'b1);
        end
        if ($urandom_range(0, 3) == 0) begin
            msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 6) begin
            msg_bytes.insert($urandom_range(0, msg_bytes.size()), CHAR_ACK);
        end
    endtask

    function automatic void check_result(input logic [15:0] d, input logic l);
        t_frame_result got;
        t_frame_result want;
        got = make_result(d[4:0], d[12:5], d[13], d[14], l);
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected result: code=%0d byte=%h valid=%b trunc=%b last=%b",
                         got.code, got.pbyte, got.pvalid, got.ptrunc, got.plast);
            end
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch: expected code=%0d byte=%h valid=%b trunc=%b last=%b",
                             want.code, want.pbyte, want.pvalid, want.ptrunc, want.plast);
                    $display("          actual   code=%0d byte=%h valid=%b trunc=%b last=%b",
                             got.code, got.pbyte, got.pvalid, got.ptrunc, got.plast);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= !(stall_enable && $urandom_range(0, 99) < 13);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        int k;
        int msg_index;
        int wait_cycles;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].data, directed_rows[r].last, directed_rows[r].typed,
                      directed_rows[r].code);
        end
        msg_index = 0;
        while (items_sent < 360) begin
            stall_enable <= !(msg_index >= 20 && msg_index < 36);
            build_message();
            for (k = 0; k < msg_bytes.size(); k++) begin
                send_item(msg_bytes[k], k == msg_bytes.size() - 1, 1'b0, CMD_NONE);
            end
            if (msg_index == 10) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            msg_index++;
        end
        s_axis_tvalid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 20000 && expected_results.size() != 0;
             wait_cycles++) begin
            @(posedge i_clk);
        end
        if (expected_results.size() != 0) begin
            $display("Missing results: %0d", expected_results.size());
            mismatches += expected_results.size();
        end
        repeat (64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
